FILE: sv/move_command_frame_parser_assert.svh
// Assertion macros for the move command frame parser.
`ifndef MOVE_COMMAND_FRAME_PARSER_ASSERT_SVH
`define MOVE_COMMAND_FRAME_PARSER_ASSERT_SVH

// Property held at every rising clock edge outside reset.
`define MCFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mcfp_pkg.sv
// Package: constants and types of the move command frame parser.
package mcfp_pkg;

    localparam int SLOTS      = 7;
    localparam int CNT_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int STEPS_W    = 17;
    localparam int PROD_W     = 16;
    localparam int M_TDATA_W  = 24;

    localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_V     = 8'h76;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
    localparam logic [BYTE_W-1:0] CH_EMPTY = 8'h00;

    localparam logic [CNT_W-1:0] CNT_FULL = 3'd7;

    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic signed [STEPS_W-1:0] steps_t;

endpackage

FILE: sv/move_command_frame_parser.sv
// Top level: move command frame parser, byte stream in, start-move step counts out.
//
//  channel | dir | payload                         | handshake
//  s_      | in  | s_tdata[7:0] rx_byte            | s_tvalid / s_tready
//  m_      | out | m_tdata[16:0] move_steps, signed| m_tvalid / m_tready
//
//  One byte per cycle while s_tready is high; each byte is folded into the frame buffer on the edge it is
//  accepted, and a start-move result is offered the cycle after, unless one still waits.
//  Synchronous active-low reset empties the buffer and zeroes the stored count.
//  Output is two deep; s_tready is registered and low only while a second result
//  waits behind a stalled one.
`include "move_command_frame_parser_assert.svh"

module move_command_frame_parser
    import mcfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [16:0] move_steps, [23:17] zero
);

    byte_t  frame_reg [SLOTS];
    cnt_t   cnt_reg;
    cnt_t   cnt_next;
    cnt_t   cnt_new;
    steps_t stored_steps_reg;
    steps_t stored_steps_next;
    logic   m_tvalid_reg;
    steps_t m_tdata_reg;
    logic   skid_valid_reg;
    steps_t skid_data_reg;

    byte_t             view [SLOTS];
    logic              accept;
    logic              wr_en;
    logic              step_hit;
    logic              start_hit;
    logic              addr_bad;
    logic              clear;
    logic [PROD_W-1:0] prod;
    steps_t            prod_pos;
    logic              res_push;
    logic              head_free;

    assign accept = s_tvalid && s_tready;
    assign wr_en  = s_tdata != CH_EMPTY;
    assign cnt_new = wr_en ? cnt_reg + cnt_t'(1) : cnt_reg;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (cnt_t'(i) >= cnt_new) begin
                view[i] = CH_EMPTY;
            end else if (wr_en && cnt_t'(i) == cnt_reg) begin
                view[i] = s_tdata;
            end else begin
                view[i] = frame_reg[i];
            end
        end
    end

    always_comb begin
        start_hit = cnt_new == CNT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
            if (view[i] != CH_S) begin
                start_hit = 1'b0;
            end
        end
    end

    assign step_hit = view[0] == CH_R && view[1] == CH_A
                   && view[5] == CH_R && view[6] == CH_A;
    assign prod     = PROD_W'(view[2]) * PROD_W'(view[3]);
    assign prod_pos = steps_t'({1'b0, prod});

    always_comb begin
        stored_steps_next = stored_steps_reg;
        if (step_hit) begin
            if (view[4] == CH_V) begin
                stored_steps_next = prod_pos;
            end else if (view[4] == CH_A) begin
                stored_steps_next = -prod_pos;
            end
        end
    end

    assign addr_bad = (view[0] != CH_R && view[0] != CH_S && view[0] != CH_EMPTY)
                   || (view[1] != CH_A && view[1] != CH_S && view[1] != CH_EMPTY);
    assign clear    = step_hit || start_hit || cnt_new == CNT_FULL || addr_bad;
    assign cnt_next = clear ? '0 : cnt_new;

    assign res_push  = accept && start_hit;
    assign head_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg          <= '0;
            stored_steps_reg <= '0;
            m_tvalid_reg     <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg          <= cnt_next;
                stored_steps_reg <= stored_steps_next;
            end
            if (head_free) begin
                m_tvalid_reg   <= skid_valid_reg || res_push;
                skid_valid_reg <= 1'b0;
            end else if (res_push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && wr_en && cnt_reg < CNT_FULL) begin
            frame_reg[cnt_reg] <= s_tdata;
        end
        if (head_free) begin
            if (skid_valid_reg) begin
                m_tdata_reg <= skid_data_reg;
            end else if (res_push) begin
                m_tdata_reg <= stored_steps_reg;
            end
        end else if (res_push) begin
            skid_data_reg <= stored_steps_reg;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - STEPS_W){1'b0}}, m_tdata_reg};

    `MCFP_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg < CNT_FULL, "frame count reached seven")
    `MCFP_ASSERT(a_ready_free, aclk, aresetn, !m_tvalid_reg |-> s_tready, "ready low while empty")
    `MCFP_ASSERT_NEXT(a_start_out, aclk, aresetn, accept && start_hit, m_tvalid_reg, "start lost")
    `MCFP_ASSERT_NEXT(a_clear, aclk, aresetn, accept && clear, cnt_reg == '0, "buffer not cleared")

endmodule
